### hdl/rfbs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the radio frame bit serializer.
// Used by the channel interfaces, the packet store and the top level.
package rfbs_pkg;

    localparam int BUFFER_BYTES_DEF = 32;

    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int MODE_W     = 2;
    localparam int PAUSE_W    = 10;
    localparam int PREAMBLE_W = 8;
    localparam int DELIM_W    = 4;
    localparam int LIMIT_W    = 4;
    localparam int STORED_W   = 6;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    // Encoding modes
    localparam logic [MODE_W-1:0] MODE_PLAIN     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HAMMING   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MANCH     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HAM_MANCH = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 3'd4;

    // Reported frame phase codes
    localparam logic [PHASE_W-1:0] FRAME_PAUSE    = 2'd0;
    localparam logic [PHASE_W-1:0] FRAME_PREAMBLE = 2'd1;
    localparam logic [PHASE_W-1:0] FRAME_DELIM    = 2'd2;
    localparam logic [PHASE_W-1:0] FRAME_DATA     = 2'd3;

    // Register reset values
    localparam logic [MODE_W-1:0]     MODE_RST     = MODE_PLAIN;
    localparam logic [PAUSE_W-1:0]    PAUSE_RST    = 10'd100;
    localparam logic [PREAMBLE_W-1:0] PREAMBLE_RST = 8'd20;
    localparam logic [DELIM_W-1:0]    DELIM_RST    = 4'd6;
    localparam logic [LIMIT_W-1:0]    LIMIT_RST    = 4'd4;

    // Codeword for each nibble
    localparam logic [BYTE_W-1:0] HAMMING_CODE [16] = '{
        8'h00, 8'h87, 8'h99, 8'h1e, 8'haa, 8'h2d, 8'h33, 8'hb4,
        8'h4b, 8'hcc, 8'hd2, 8'h55, 8'he1, 8'h66, 8'h78, 8'hff
    };

    // Store write request: one byte, or two consecutive bytes when pair is set
    typedef struct packed {
        logic              en;
        logic              pair;
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
    } rfbs_wr_t;

endpackage

### hdl/rfbs_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: command input, result output, register write.
// Depends on rfbs_pkg for field widths.
interface rfbs_cmd_if
    import rfbs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface rfbs_res_if
    import rfbs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                line_bit;
    logic                accepted;
    logic [PHASE_W-1:0]  frame_phase;
    logic [STORED_W-1:0] stored_bytes;

    modport source (output valid, output line_bit, output accepted, output frame_phase,
                    output stored_bytes, input ready);
    modport sink (input valid, input line_bit, input accepted, input frame_phase,
                  input stored_bytes, output ready);
endinterface

interface rfbs_cfg_if
    import rfbs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/rfbs_store.sv
`timescale 1ns / 1ps
// Packet store: two banks (even and odd entries) so both bytes of a codeword pair are written in the same cycle.
// Per-entry valid flops give the all-zero reset contents. Depends on rfbs_pkg.
module rfbs_store
    import rfbs_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int CTR_W        = PAUSE_W
)(
    input  logic                            clk,
    input  logic                            rst_n,
    input  rfbs_wr_t                        wr,
    input  logic [$clog2(BUFFER_BYTES)-1:0] wr_idx,
    input  logic [CTR_W-1:0]                rd_ctr,
    output logic [BYTE_W-1:0]               rd_byte
);

    localparam int IDX_W      = $clog2(BUFFER_BYTES);
    localparam int BANK_DEPTH = (BUFFER_BYTES + 1) / 2;
    localparam int BANK_AW    = (IDX_W > 1) ? IDX_W - 1 : 1;
    localparam int RIDX_W     = CTR_W - 3;

    logic [BYTE_W-1:0] even_mem [BANK_DEPTH];
    logic [BYTE_W-1:0] odd_mem  [BANK_DEPTH];

    logic [BUFFER_BYTES-1:0] valid_reg, valid_next;
    logic [BYTE_W-1:0]       even_q_reg, odd_q_reg, byp_data_reg, byp_data_next;
    logic                    hit_reg, hit_next, live_reg, sel_reg;

    logic [IDX_W-1:0]   idx0, idx1, rd_e;
    logic [RIDX_W-1:0]  rd_e_wide;
    logic               in_range;
    logic [BANK_AW-1:0] rd_addr, even_addr, odd_addr;
    logic               even_en, odd_en;
    logic [BYTE_W-1:0]  even_data, odd_data;

    assign idx0 = wr_idx;
    assign idx1 = wr_idx + 1'b1;

    always_comb
    begin
        even_en   = wr.en && (!idx0[0] || (wr.pair && !idx1[0]));
        odd_en    = wr.en && (idx0[0] || (wr.pair && idx1[0]));
        even_addr = !idx0[0] ? BANK_AW'(idx0 >> 1) : BANK_AW'(idx1 >> 1);
        odd_addr  = idx0[0] ? BANK_AW'(idx0 >> 1) : BANK_AW'(idx1 >> 1);
        even_data = !idx0[0] ? wr.byte0 : wr.byte1;
        odd_data  = idx0[0] ? wr.byte0 : wr.byte1;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[idx0] = 1'b1;
        end
        if (wr.en && wr.pair)
        begin
            valid_next[idx1] = 1'b1;
        end
    end

    // Read side: fetch the entry the counter will point at next; forward a same-cycle write
    assign rd_e_wide = rd_ctr[CTR_W-1:3];
    assign in_range  = rd_e_wide < RIDX_W'(BUFFER_BYTES);
    assign rd_e      = IDX_W'(rd_e_wide);
    assign rd_addr   = BANK_AW'(rd_e >> 1);

    always_comb
    begin
        hit_next      = 1'b0;
        byp_data_next = wr.byte0;
        if (in_range && wr.en && idx0 == rd_e)
        begin
            hit_next = 1'b1;
        end
        else if (in_range && wr.en && wr.pair && idx1 == rd_e)
        begin
            hit_next      = 1'b1;
            byp_data_next = wr.byte1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (even_en)
        begin
            even_mem[even_addr] <= even_data;
        end
        if (odd_en)
        begin
            odd_mem[odd_addr] <= odd_data;
        end
        even_q_reg   <= even_mem[rd_addr];
        odd_q_reg    <= odd_mem[rd_addr];
        byp_data_reg <= byp_data_next;
        sel_reg      <= rd_e[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
            live_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
            live_reg  <= in_range && valid_reg[rd_e];
        end
    end

    always_comb
    begin
        if (hit_reg)
        begin
            rd_byte = byp_data_reg;
        end
        else if (live_reg)
        begin
            rd_byte = sel_reg ? odd_q_reg : even_q_reg;
        end
        else
        begin
            rd_byte = '0;
        end
    end

endmodule

### hdl/radio_frame_bit_serializer_unit.sv
`timescale 1ns / 1ps
// Top level of the radio frame bit serializer: channel handshakes, registers, frame sequencer.
// Depends on rfbs_pkg, the rfbs_*_if interfaces and rfbs_store.
//
// The block takes one command per clock cycle (clear, append a byte, or one bit-time tick)
// while results drain, and returns exactly one result per command. Each command passes an
// input register, the frame logic and a result register before its result is offered; while
// the result register holds a result that is not taken, a new command waits in the input
// register and the input stalls. The packet store is a two-bank memory, so both bytes of an
// encoded pair are written in the same cycle; the entry under the bit counter is fetched from
// the counter's next value, in the cycle before the counter reaches it, with same-cycle writes
// forwarded. Store contents read as zero after reset through per-entry valid flops: no clearing
// pass, commands are taken from the first cycle. Register writes are taken every cycle; indexes
// past the last register are ignored.
module radio_frame_bit_serializer_unit
    import rfbs_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)(
    input logic       clk,
    input logic       rst_n,
    rfbs_cmd_if.sink  cmd,
    rfbs_res_if.source res,
    rfbs_cfg_if.sink  cfg
);

    localparam int LEN_W = $clog2(BUFFER_BYTES + 1);
    localparam int IDX_W = $clog2(BUFFER_BYTES);
    localparam int CTR_W = (BUFFER_BYTES * 8 + 1 > (1 << PAUSE_W)) ?
                           $clog2(BUFFER_BYTES * 8 + 1) : PAUSE_W;

    typedef enum logic [3:0] {
        PH_PAUSE    = 4'b0001,
        PH_PREAMBLE = 4'b0010,
        PH_DELIM    = 4'b0100,
        PH_DATA     = 4'b1000
    } phase_t;

    function automatic logic [PHASE_W-1:0] phase_code(phase_t p);
        logic [PHASE_W-1:0] c;
        unique case (p)
            PH_PAUSE:    c = FRAME_PAUSE;
            PH_PREAMBLE: c = FRAME_PREAMBLE;
            PH_DELIM:    c = FRAME_DELIM;
            PH_DATA:     c = FRAME_DATA;
            default:     c = FRAME_PAUSE;
        endcase
        return c;
    endfunction

    // Registers
    logic [MODE_W-1:0]     mode_reg;
    logic [PAUSE_W-1:0]    pause_reg;
    logic [PREAMBLE_W-1:0] preamble_reg;
    logic [DELIM_W-1:0]    delim_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    // Input register
    logic              inq_valid_reg;
    logic [CMD_W-1:0]  inq_cmd_reg;
    logic [BYTE_W-1:0] inq_data_reg;

    // Frame state
    phase_t             phase_reg, phase_next;
    logic [CTR_W-1:0]   ctr_reg, ctr_next;
    logic [LIMIT_W-1:0] zrun_reg, zrun_next;
    logic               half_reg, half_next;
    logic [LEN_W-1:0]   len_reg, len_next;

    // Result register
    logic                res_valid_reg;
    logic                res_line_reg, res_line_next;
    logic                res_ok_reg, res_ok_next;
    logic [PHASE_W-1:0]  res_phase_reg;
    logic [STORED_W-1:0] res_len_reg;

    logic              fire;
    logic              is_tick;
    logic              hamming_mode, manch_mode;
    logic [LEN_W:0]    len_ext;
    logic [CTR_W-1:0]  ctr_inc, ctr_step, data_end;
    logic              data_bit;
    logic [BYTE_W-1:0] cur_byte;
    rfbs_wr_t          wr;
    logic [IDX_W-1:0]  wr_idx;

    assign fire      = inq_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !inq_valid_reg || fire;
    assign cfg.ready = 1'b1;

    assign hamming_mode = (mode_reg == MODE_HAMMING) || (mode_reg == MODE_HAM_MANCH);
    assign manch_mode   = (mode_reg == MODE_MANCH) || (mode_reg == MODE_HAM_MANCH);
    assign is_tick      = fire && (inq_cmd_reg == CMD_TICK);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_RST;
            pause_reg    <= PAUSE_RST;
            preamble_reg <= PREAMBLE_RST;
            delim_reg    <= DELIM_RST;
            limit_reg    <= LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MODE:     mode_reg     <= cfg.data[MODE_W-1:0];
                CFG_PAUSE:    pause_reg    <= cfg.data[PAUSE_W-1:0];
                CFG_PREAMBLE: preamble_reg <= cfg.data[PREAMBLE_W-1:0];
                CFG_DELIM:    delim_reg    <= cfg.data[DELIM_W-1:0];
                CFG_LIMIT:    limit_reg    <= cfg.data[LIMIT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Buffer commands
    assign len_ext = (LEN_W + 1)'(len_reg);
    assign wr_idx  = IDX_W'(len_reg);

    always_comb
    begin
        len_next    = len_reg;
        wr.en       = 1'b0;
        wr.pair     = hamming_mode;
        wr.byte0    = hamming_mode ? HAMMING_CODE[inq_data_reg[3:0]] : inq_data_reg;
        wr.byte1    = HAMMING_CODE[inq_data_reg[7:4]];
        res_ok_next = 1'b0;
        if (fire)
        begin
            unique case (inq_cmd_reg)
                CMD_CLEAR:
                begin
                    len_next    = '0;
                    res_ok_next = 1'b1;
                end
                CMD_APPEND:
                begin
                    if (hamming_mode && (len_ext + 2'd2 <= (LEN_W + 1)'(BUFFER_BYTES)))
                    begin
                        wr.en       = 1'b1;
                        len_next    = LEN_W'(len_ext + 2'd2);
                        res_ok_next = 1'b1;
                    end
                    else if (!hamming_mode && (len_ext + 1'b1 <= (LEN_W + 1)'(BUFFER_BYTES)))
                    begin
                        wr.en       = 1'b1;
                        len_next    = LEN_W'(len_ext + 1'b1);
                        res_ok_next = 1'b1;
                    end
                end
                CMD_TICK:
                begin
                    res_ok_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Frame sequencer, advanced by tick transactions
    assign ctr_inc  = ctr_reg + 1'b1;
    assign data_end = CTR_W'({len_reg, 3'b000});
    assign data_bit = cur_byte[ctr_reg[2:0]];

    always_comb
    begin
        phase_next    = phase_reg;
        ctr_next      = ctr_reg;
        zrun_next     = zrun_reg;
        half_next     = half_reg;
        ctr_step      = ctr_reg;
        res_line_next = 1'b0;
        if (is_tick)
        begin
            unique case (phase_reg)
                PH_PAUSE:
                begin
                    ctr_next = ctr_inc;
                    if (ctr_inc >= CTR_W'(pause_reg))
                    begin
                        ctr_next      = '0;
                        phase_next    = PH_PREAMBLE;
                        res_line_next = 1'b1;
                    end
                end
                PH_PREAMBLE:
                begin
                    res_line_next = 1'b1;
                    ctr_next      = ctr_inc;
                    if (ctr_inc >= CTR_W'(preamble_reg))
                    begin
                        ctr_next   = '0;
                        phase_next = PH_DELIM;
                    end
                end
                PH_DELIM:
                begin
                    res_line_next = ctr_reg[0];
                    ctr_next      = ctr_inc;
                    if (ctr_inc >= CTR_W'(delim_reg))
                    begin
                        ctr_next   = '0;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (manch_mode)
                    begin
                        res_line_next = data_bit ^ half_reg;
                        ctr_step      = half_reg ? ctr_inc : ctr_reg;
                        half_next     = !half_reg;
                    end
                    else if (data_bit)
                    begin
                        zrun_next     = '0;
                        res_line_next = 1'b1;
                        ctr_step      = ctr_inc;
                    end
                    else if (limit_reg != '0 && zrun_reg == limit_reg)
                    begin
                        // stuffed one: hold the bit counter
                        zrun_next     = '0;
                        res_line_next = 1'b1;
                    end
                    else
                    begin
                        zrun_next = zrun_reg + 1'b1;
                        ctr_step  = ctr_inc;
                    end
                    ctr_next = ctr_step;
                    if (ctr_step >= data_end)
                    begin
                        zrun_next  = '0;
                        ctr_next   = '0;
                        phase_next = PH_PAUSE;
                    end
                end
                default:
                begin
                    phase_next = PH_PAUSE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_PAUSE;
            ctr_reg       <= '0;
            zrun_reg      <= '0;
            half_reg      <= 1'b0;
            len_reg       <= '0;
        end
        else
        begin
            if (cmd.ready)
            begin
                inq_valid_reg <= cmd.valid;
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            phase_reg <= phase_next;
            ctr_reg   <= ctr_next;
            zrun_reg  <= zrun_next;
            half_reg  <= half_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            inq_cmd_reg  <= cmd.command;
            inq_data_reg <= cmd.data_byte;
        end
        if (fire)
        begin
            res_line_reg  <= res_line_next;
            res_ok_reg    <= res_ok_next;
            res_phase_reg <= phase_code(phase_next);
            res_len_reg   <= STORED_W'(len_next);
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.line_bit     = res_line_reg;
    assign res.accepted     = res_ok_reg;
    assign res.frame_phase  = res_phase_reg;
    assign res.stored_bytes = res_len_reg;

    rfbs_store #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .CTR_W        (CTR_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .wr_idx  (wr_idx),
        .rd_ctr  (ctr_next),
        .rd_byte (cur_byte)
    );

    // Checks
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(BUFFER_BYTES))
        else $error("stored length beyond buffer capacity");

    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("processed transaction left no result");

    a_phase_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != $past(phase_reg)) |-> $past(is_tick))
        else $error("frame phase moved without a tick");

    a_data_from_delim: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA && $past(phase_reg) != PH_DATA) |-> $past(phase_reg) == PH_DELIM)
        else $error("data phase entered from outside delimiter");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (inq_valid_reg && res_valid_reg && !res.ready))
        else $error("input stalled with room downstream");

endmodule
